// ===== src/pba_pkg.sv =====
// Shared types, constants and helpers for the page bitmap allocator.
// Used by pba_ctrl, page_bitmap_allocator and the testbench.
package pba_pkg;

	// Default page count and the page range the 12-bit page field can reach
	localparam int unsigned PAGES_DEFAULT = 4096;
	localparam int unsigned FIELD_PAGES   = 4096;
	localparam int unsigned BYTE_BITS     = 8;

	localparam logic [7:0]  FULL_BYTE     = 8'hff;
	localparam logic [11:0] START_BACKOFF = 12'd10;
	localparam logic [12:0] MEM_PAGES_RST = 13'd4096;

	// Operation codes carried in s_tuser
	localparam logic [1:0] KIND_MARK    = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_FIND    = 2'd2;

	// Configuration register indexes
	localparam logic REG_SEARCH_START = 1'b0;
	localparam logic REG_MEMORY_PAGES = 1'b1;

	// One result as it leaves the controller
	typedef struct packed {
		logic        status;
		logic        found;
		logic [11:0] free_page;
	} res_t;

	// Index of the lowest clear bit of a byte (byte must not be full)
	function automatic logic [2:0] first_zero(input logic [7:0] b);
		logic [2:0] idx;
		logic       seen;
		idx  = 3'd0;
		seen = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!seen && !b[i]) begin
				idx  = 3'(i);
				seen = 1'b1;
			end
		end
		return idx;
	endfunction

endpackage

// ===== src/pba_bitmap_ram.sv =====
// Single-port-write, single-port-read bitmap byte store with a registered read.
// No dependencies beyond its parameters.
module pba_bitmap_ram #(
	parameter int unsigned DEPTH = 512,
	parameter int unsigned AW    = 9
) (
	input  logic          clk,
	input  logic          rd,
	input  logic          wr,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr) begin
			mem[addr] <= wdata;
		end
	end

	// Registered read, held between reads
	always_ff @(posedge clk) begin
		if (rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/pba_ctrl.sv =====
// Operation sequencer: clearing pass, mark/release read-modify-write, byte scan.
// Depends on pba_pkg; drives the ports of pba_bitmap_ram.
module pba_ctrl
	import pba_pkg::*;
#(
	parameter int unsigned PAGES = PAGES_DEFAULT,
	parameter int unsigned DEPTH = 512,
	parameter int unsigned AW    = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    in_kind,
	input  logic [11:0]   in_page,
	input  logic [8:0]    start_byte,
	input  logic [9:0]    end_byte,
	output logic          res_valid,
	input  logic          res_ready,
	output res_t          res,
	output logic          mem_rd,
	output logic          mem_wr,
	output logic [AW-1:0] mem_addr,
	output logic [7:0]    mem_wdata,
	input  logic [7:0]    mem_rdata
);

	typedef enum logic [4:0] {
		ST_CLR  = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_RMW  = 5'b00100,
		ST_FIND = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_q;
	logic [11:0]   page_q;
	logic [1:0]    kind_q;
	logic [9:0]    b_q;
	logic          pend_q;
	logic [9:0]    pend_b_q;
	res_t          res_q;

	logic       accept;
	logic       in_range;
	logic       in_err;
	logic [7:0] bit_mask;
	logic       bit_set;
	logic       scan_hit;
	logic       scan_end;

	assign accept   = in_valid && in_ready;
	assign in_range = 32'(in_page) < 32'(PAGES);
	// out-of-range mark/release and unknown kinds finish at once with an error
	assign in_err   = (in_kind == KIND_MARK || in_kind == KIND_RELEASE) ? !in_range :
		(in_kind != KIND_FIND);
	assign bit_mask = 8'(1) << page_q[2:0];
	assign bit_set  = (mem_rdata & bit_mask) != 8'd0;
	assign scan_hit = pend_q && (mem_rdata != FULL_BYTE);
	assign scan_end = b_q >= end_byte;

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	// Memory request steering
	always_comb begin
		mem_rd    = 1'b0;
		mem_wr    = 1'b0;
		mem_addr  = clr_q;
		mem_wdata = 8'd0;
		case (state_q)
			ST_CLR: begin
				mem_wr = 1'b1;
			end
			ST_IDLE: begin
				mem_addr = in_page[AW+2:3];
				mem_rd   = accept && in_range &&
					(in_kind == KIND_MARK || in_kind == KIND_RELEASE);
			end
			ST_RMW: begin
				mem_addr = page_q[AW+2:3];
				if (kind_q == KIND_MARK) begin
					mem_wr    = !bit_set;
					mem_wdata = mem_rdata | bit_mask;
				end else begin
					mem_wr    = bit_set;
					mem_wdata = mem_rdata & ~bit_mask;
				end
			end
			ST_FIND: begin
				mem_addr = b_q[AW-1:0];
				mem_rd   = !scan_hit && !scan_end;
			end
			default: begin
				mem_rd = 1'b0;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						page_q <= in_page;
						kind_q <= in_kind;
						b_q    <= {1'b0, start_byte};
						pend_q <= 1'b0;
						res_q  <= '{status: in_err, found: 1'b0, free_page: 12'd0};
						if (in_err) begin
							state_q <= ST_DONE;
						end else if (in_kind == KIND_FIND) begin
							state_q <= ST_FIND;
						end else begin
							state_q <= ST_RMW;
						end
					end
				end
				ST_RMW: begin
					// error when the bit already holds the requested value
					res_q.status <= (kind_q == KIND_MARK) ? bit_set : !bit_set;
					state_q      <= ST_DONE;
				end
				ST_FIND: begin
					if (scan_hit) begin
						res_q.found     <= 1'b1;
						res_q.free_page <= {pend_b_q[8:0], first_zero(mem_rdata)};
						state_q         <= ST_DONE;
					end else if (scan_end) begin
						state_q <= ST_DONE;
					end else begin
						pend_q   <= 1'b1;
						pend_b_q <= b_q;
						b_q      <= b_q + 10'd1;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The scan never modifies the bitmap
	a_find_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIND) |-> !mem_wr)
		else $error("bitmap written during scan");

	// Scan reads stay below the end byte
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIND && mem_rd) |-> (b_q < end_byte))
		else $error("scan read past end byte");

	// A mark/release write follows the read of the same byte
	a_rmw_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RMW && mem_wr) |-> ($past(mem_rd) && $past(mem_addr) == mem_addr))
		else $error("write without matching read");

endmodule

// ===== src/page_bitmap_allocator.sv =====
// Top level of the page bitmap allocator: config registers, output register.
// Depends on pba_pkg, pba_ctrl and pba_bitmap_ram.
//
//  channel  | direction | transfer payload
//  s_*      | in        | tuser[1:0] kind, tdata[11:0] page
//  m_*      | out       | tuser[0] status, tuser[1] found, tdata[11:0] free_page
//  cfg_*    | in        | cfg_index register, cfg_data[12:0] value
//
// Mark and release go through read, modify/write and hand-off, with m_tvalid raised from
// the output register; an out-of-range page or unknown kind skips the read and write.
// Find reads and checks the bitmap one byte at a time; one read port sets the pace.
// After reset a clearing pass writes every bitmap byte (512 at the default size) and runs
// with s_tready low; configuration writes are taken throughout.
// A stalled m_* side holds one finished result while the next item is taken in and worked.
module page_bitmap_allocator
	import pba_pkg::*;
#(
	parameter int unsigned PAGES = PAGES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] page, [15:12] zero
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [11:0] free_page, [15:12] zero
	output logic [1:0]  m_tuser,   // [0] status, [1] found
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int unsigned MAP_BYTES = (PAGES + BYTE_BITS - 1) / BYTE_BITS;
	localparam int unsigned DEPTH     = (MAP_BYTES < FIELD_PAGES / BYTE_BITS) ?
		MAP_BYTES : FIELD_PAGES / BYTE_BITS;
	localparam int unsigned AW        = $clog2(DEPTH);
	localparam int unsigned PAGE_CAP  = (PAGES < FIELD_PAGES) ? PAGES : FIELD_PAGES;

	logic [11:0]   ssp_q;
	logic [12:0]   mp_q;
	logic [12:0]   limit;
	logic [8:0]    start_byte;
	logic [9:0]    end_byte;
	logic          res_valid;
	logic          res_ready;
	res_t          res;
	logic          m_valid_q;
	res_t          out_q;
	logic          mem_rd;
	logic          mem_wr;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic [7:0]    mem_rdata;

	// Configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ssp_q <= 12'd0;
			mp_q  <= MEM_PAGES_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SEARCH_START) begin
				ssp_q <= cfg_data[11:0];
			end else begin
				mp_q <= cfg_data;
			end
		end
	end

	// Scan window in bytes
	assign limit      = (32'(mp_q) < PAGE_CAP) ? mp_q : 13'(PAGE_CAP);
	assign end_byte   = limit[12:3];
	assign start_byte = (ssp_q >= START_BACKOFF) ? 9'((ssp_q - START_BACKOFF) >> 3) : 9'd0;

	pba_ctrl #(
		.PAGES (PAGES),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (s_tuser),
		.in_page    (s_tdata[11:0]),
		.start_byte (start_byte),
		.end_byte   (end_byte),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mem_rd     (mem_rd),
		.mem_wr     (mem_wr),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata)
	);

	pba_bitmap_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.rd    (mem_rd),
		.wr    (mem_wr),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Output register
	assign res_ready = !m_valid_q || m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, out_q.free_page};
	assign m_tuser  = {out_q.found, out_q.status};

endmodule

// ===== tb/page_bitmap_allocator_test.sv =====
// Self-checking testbench for page_bitmap_allocator: a directed run, then random phases.
// Depends on pba_pkg and the page_bitmap_allocator RTL; needs no other file.
module page_bitmap_allocator_test
	import pba_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAP_PAGES   = PAGES_DEFAULT;
	localparam int unsigned MAP_BYTES   = (MAP_PAGES + 7) / 8;
	localparam logic [1:0]  KIND_BAD    = 2'd3;   // not an operation, gives an error
	localparam int unsigned RAND_PHASES = 12;
	localparam int unsigned PHASE_OPS   = 127;
	localparam int unsigned DRAIN_WAIT  = 600;    // longer than the slowest search

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] page;
	} page_op_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;    // [11:0] page, [15:12] zero
	logic [1:0]  s_tuser = '0;    // [1:0] kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // [11:0] free_page, [15:12] zero
	logic [1:0]  m_tuser;         // [0] status, [1] found
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [12:0] cfg_data = '0;

	// Shadow of the block: bitmap and both registers
	logic [7:0]  used_map [MAP_BYTES];
	logic [11:0] scan_from = '0;
	logic [12:0] mem_limit = MEM_PAGES_RST;

	page_op_t    pending_ops[$];
	res_t        awaited_results[$];
	page_op_t    drive_op;
	res_t        got_res;
	res_t        want_res;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_left = 0;
	int unsigned cyc_count = 0;
	int unsigned errors = 0;

	page_bitmap_allocator #(
		.PAGES(MAP_PAGES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	initial begin
		for (int i = 0; i < MAP_BYTES; i++) begin
			used_map[i] = '0;
		end
	end

	// Apply one operation to the shadow bitmap and work out its result
	function automatic res_t apply_page_op(input logic [1:0] kind, input logic [11:0] page);
		res_t        r;
		int unsigned lim;
		int unsigned end_byte;
		int unsigned b;
		int unsigned bit_idx;
		logic        want_used;
		r = '0;
		case (kind)
			KIND_MARK, KIND_RELEASE: begin
				want_used = (kind == KIND_MARK);
				if (page >= MAP_PAGES) begin
					r.status = 1'b1;
				end else if (used_map[page[11:3]][page[2:0]] == want_used) begin
					r.status = 1'b1;
				end else begin
					used_map[page[11:3]][page[2:0]] = want_used;
				end
			end
			KIND_FIND: begin
				lim = mem_limit;
				if (lim > MAP_PAGES) lim = MAP_PAGES;
				if (lim > FIELD_PAGES) lim = FIELD_PAGES;
				end_byte = lim / BYTE_BITS;
				b = (scan_from >= START_BACKOFF) ? (scan_from - START_BACKOFF) / BYTE_BITS : 0;
				while (b < end_byte && used_map[b] == FULL_BYTE) b++;
				if (b < end_byte) begin
					bit_idx = 0;
					while (used_map[b][bit_idx]) bit_idx++;
					r.found     = 1'b1;
					r.free_page = 12'(b * BYTE_BITS + bit_idx);
				end
			end
			default: begin
				r.status = 1'b1;
			end
		endcase
		return r;
	endfunction

	task automatic add_op(input logic [1:0] kind, input logic [11:0] page);
		page_op_t op;
		op.kind = kind;
		op.page = page;
		pending_ops.push_back(op);
	endtask

	// Wait until every queued item has gone in and every result has come back
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_ops.size() != 0 || s_tvalid || awaited_results.size() != 0);
	endtask

	// One register write; the shadow takes the value at the transfer
	task automatic write_reg(input logic idx, input logic [12:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_SEARCH_START) scan_from = value[11:0];
		else mem_limit = value;
	endtask

	// Random settings for one phase, both registers written in random order
	task automatic pick_config();
		logic [12:0] start_val;
		logic [12:0] pages_val;
		case ($urandom_range(0, 4))
			0: start_val = '0;
			1: start_val = 13'($urandom_range(0, 9));
			2: start_val = 13'(4095);
			3: start_val = 13'($urandom_range(0, 8191));
			default: start_val = 13'($urandom_range(10, 4095));
		endcase
		case ($urandom_range(0, 6))
			0: pages_val = '0;
			1: pages_val = 13'(8191);
			2: pages_val = 13'($urandom_range(0, 8191));
			3: pages_val = 13'($urandom_range(0, 4096));
			default: pages_val = MEM_PAGES_RST;
		endcase
		if ($urandom_range(0, 1)) begin
			write_reg(REG_SEARCH_START, start_val);
			write_reg(REG_MEMORY_PAGES, pages_val);
		end else begin
			write_reg(REG_MEMORY_PAGES, pages_val);
			write_reg(REG_SEARCH_START, start_val);
		end
	endtask

	// Random phase: work around the search start so that bytes fill and searches run long
	task automatic gen_phase(input int unsigned count);
		int unsigned first_page;
		int unsigned span;
		int unsigned base_byte;
		int unsigned n_bytes;
		int unsigned added;
		int unsigned sel;
		int unsigned k;
		int unsigned n_rel;
		first_page = (scan_from >= START_BACKOFF) ? scan_from - START_BACKOFF : 0;
		span  = $urandom_range(8, 64);
		added = 0;
		while (added < count) begin
			sel = $urandom_range(0, 9);
			if (sel < 5) begin
				// single operation inside the window, biased towards marking
				k = $urandom_range(0, 9);
				add_op((k < 6) ? KIND_MARK : (k < 8) ? KIND_RELEASE : KIND_FIND,
					12'(first_page + $urandom_range(0, span - 1)));
				added++;
			end else if (sel < 7) begin
				// fill a run of whole bytes from near the start, then search
				base_byte = first_page / BYTE_BITS + $urandom_range(0, 3);
				n_bytes   = $urandom_range(1, 4);
				for (int j = 0; j < n_bytes * BYTE_BITS; j++) begin
					add_op(KIND_MARK, 12'(base_byte * BYTE_BITS + j));
				end
				add_op(KIND_FIND, 12'($urandom_range(0, 4095)));
				added += n_bytes * BYTE_BITS + 1;
			end else if (sel < 8) begin
				// free a few pages in the window, then search
				n_rel = $urandom_range(1, 6);
				repeat (n_rel) add_op(KIND_RELEASE, 12'(first_page + $urandom_range(0, span - 1)));
				add_op(KIND_FIND, 12'($urandom_range(0, 4095)));
				added += n_rel + 1;
			end else begin
				// noise: any kind, any page
				add_op(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)));
				added++;
			end
		end
	endtask

	// Sender: bursts of transfers with random gaps in between
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				awaited_results.push_back(apply_page_op(s_tuser, s_tdata[11:0]));
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0 || pending_ops.size() == 0) begin
					if (gap_left > 0) gap_left--;
					s_tvalid <= 1'b0;
				end else begin
					drive_op = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= drive_op.kind;
					s_tdata  <= {4'b0, drive_op.page};
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						if ($urandom_range(0, 3) == 0) gap_left = 0;
						else gap_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 60 : 6);
					end
				end
			end
		end
	end

	// Receiver: compare each result transfer, then pick the next ready level
	always @(posedge clk) begin
		cyc_count++;
		if (arst_n && m_tvalid && m_tready) begin
			got_res.status    = m_tuser[0];
			got_res.found     = m_tuser[1];
			got_res.free_page = m_tdata[11:0];
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, got_res);
			end else begin
				want_res = awaited_results.pop_front();
				if (got_res.status !== want_res.status) begin
					errors++;
					$display("%0t: status expected %b actual %b", $time,
						want_res.status, got_res.status);
				end
				if (got_res.found !== want_res.found) begin
					errors++;
					$display("%0t: found expected %b actual %b", $time,
						want_res.found, got_res.found);
				end
				if (got_res.free_page !== want_res.free_page) begin
					errors++;
					$display("%0t: free_page expected %h actual %h", $time,
						want_res.free_page, got_res.free_page);
				end
			end
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 4) == 0);
			default: m_tready <= cyc_count[3];
		endcase
	end

	// Stimulus and end of run
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: empty map, double mark and release, top page, bad kind
		add_op(KIND_FIND, 12'h000);
		add_op(KIND_MARK, 12'h000);
		add_op(KIND_MARK, 12'h000);
		add_op(KIND_RELEASE, 12'h000);
		add_op(KIND_RELEASE, 12'h000);
		add_op(KIND_MARK, 12'hfff);
		add_op(KIND_RELEASE, 12'hfff);
		add_op(KIND_BAD, 12'hfff);
		for (int p = 0; p < 8; p++) add_op(KIND_MARK, 12'(p));
		add_op(KIND_FIND, 12'hfff);
		wait_idle();

		// start below the backoff scans from byte 0
		write_reg(REG_SEARCH_START, 13'd5);
		add_op(KIND_FIND, 12'h000);
		wait_idle();

		// trailing partial byte is not scanned
		write_reg(REG_MEMORY_PAGES, 13'd13);
		add_op(KIND_FIND, 12'h000);
		wait_idle();

		// no pages at all
		write_reg(REG_MEMORY_PAGES, 13'd0);
		add_op(KIND_FIND, 12'h000);
		wait_idle();

		// highest start, page count above the map size
		write_reg(REG_SEARCH_START, 13'd4095);
		write_reg(REG_MEMORY_PAGES, 13'd8191);
		add_op(KIND_FIND, 12'h000);
		add_op(KIND_MARK, 12'haaa);
		add_op(KIND_RELEASE, 12'haaa);
		add_op(KIND_MARK, 12'h555);
		wait_idle();

		// start byte equal to end byte gives an empty range
		write_reg(REG_MEMORY_PAGES, 13'd4080);
		add_op(KIND_FIND, 12'h000);
		wait_idle();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			pick_config();
			gen_phase(PHASE_OPS);
			wait_idle();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && awaited_results.size() == 0) begin
			$display("** page_bitmap_allocator: PASSED **");
		end else begin
			$display("** page_bitmap_allocator: FAILED **");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#40_000_000;
		$display("** page_bitmap_allocator: FAILED **");
		$finish;
	end

endmodule
